>>> rtl/core/ppsc_pkg.sv
// ppsc_pkg: shared types and constants for the pulse pair speed and period capture block
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package ppsc_pkg;

	localparam int unsigned TickW = 32;

	localparam logic [TickW-1:0] GAP_TIMEOUT_RST = 32'd700;
	localparam logic [TickW-1:0] SPEED_MAX       = 32'h7FFF_FFFF;

	typedef logic [TickW-1:0] tick_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	// one sample word as held in the input stage
	typedef struct packed {
		logic  sensor_level;
		tick_t tick_now;
	} sample_t;

	// one result word
	typedef struct packed {
		logic signed [TickW-1:0] signed_speed;
		tick_t                   swing_period;
	} result_t;

	// tracker status seen by the stage control
	typedef struct packed {
		logic    emit;
		result_t res;
	} trk_status_t;

endpackage

>>> rtl/core/ppsc_chan_if.sv
// ppsc_chan_if: valid/ready channel interfaces for sample words and result words
// depends on ppsc_pkg
`timescale 1ns / 1ps

interface ppsc_sample_if import ppsc_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  sensor_level;
	tick_t tick_now;

	modport source (output valid, output sensor_level, output tick_now, input ready);
	modport sink (input valid, input sensor_level, input tick_now, output ready);
endinterface

interface ppsc_result_if import ppsc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [TickW-1:0] signed_speed;
	tick_t                   swing_period;

	modport source (output valid, output signed_speed, output swing_period, input ready);
	modport sink (input valid, input signed_speed, input swing_period, output ready);
endinterface

>>> rtl/core/ppsc_input_stage.sv
// ppsc_input_stage: registers one sample word and holds it until the tracker consumes it
// depends on ppsc_pkg and ppsc_sample_if
`timescale 1ns / 1ps

module ppsc_input_stage import ppsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ppsc_sample_if.sink      sample,
	input  logic             advance,
	output logic             valid_s1,
	output sample_t          data_s1
);

	logic load;

	assign sample.ready = !valid_s1 || advance;
	assign load         = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1.sensor_level <= sample.sensor_level;
			data_s1.tick_now     <= sample.tick_now;
		end
	end

endmodule

>>> rtl/core/ppsc_pair_tracker.sv
// ppsc_pair_tracker: pulse pair state, timeout check, edge handling and result arithmetic
// depends on ppsc_pkg; fed by ppsc_input_stage, drains into ppsc_result_reg
`timescale 1ns / 1ps

module ppsc_pair_tracker import ppsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  tick_t       cfg_wdata,
	input  logic        valid_s1,
	input  sample_t     data_s1,
	input  logic        advance,
	output trk_status_t status
);

	tick_t  gap_timeout_q;
	logic   last_level_q;
	phase_t phase_q;
	tick_t  last_rise_q;
	tick_t  first_rise_q;
	tick_t  first_width_q;
	tick_t  last_emit_q;

	tick_t  since_rise;
	logic   timed_out;
	phase_t phase_eff;
	logic   level_eff;
	logic   rise;
	logic   fall;
	tick_t  mag;
	tick_t  mag_sat;
	tick_t  speed;

	// timeout is judged before edge detection and clears the remembered level
	assign since_rise = data_s1.tick_now - last_rise_q;
	assign timed_out  = since_rise > gap_timeout_q;
	assign phase_eff  = timed_out ? PH_IDLE : phase_q;
	assign level_eff  = timed_out ? 1'b0 : last_level_q;
	assign rise       = data_s1.sensor_level && !level_eff;
	assign fall       = !data_s1.sensor_level && level_eff;

	// since_rise doubles as the width of the pulse now falling
	assign mag     = data_s1.tick_now - first_rise_q;
	assign mag_sat = mag[TickW-1] ? SPEED_MAX : mag;
	assign speed   = (first_width_q > since_rise) ? (~mag_sat + 1'b1) : mag_sat;

	assign status.emit             = valid_s1 && fall && (phase_eff == PH_SECOND);
	assign status.res.signed_speed = $signed(speed);
	assign status.res.swing_period = data_s1.tick_now - last_emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_timeout_q <= GAP_TIMEOUT_RST;
			last_level_q  <= 1'b0;
			phase_q       <= PH_IDLE;
			last_rise_q   <= '0;
			first_rise_q  <= '0;
			first_width_q <= '0;
			last_emit_q   <= '0;
		end else begin
			if (cfg_we) begin
				gap_timeout_q <= cfg_wdata;
			end
			if (advance) begin
				last_level_q <= data_s1.sensor_level;
				phase_q      <= phase_eff;
				if (rise) begin
					last_rise_q <= data_s1.tick_now;
					if (phase_eff == PH_FIRST) begin
						phase_q <= PH_SECOND;
					end else begin
						first_rise_q <= data_s1.tick_now;
						phase_q      <= PH_FIRST;
					end
				end else if (fall) begin
					case (phase_eff)
						PH_FIRST: begin
							first_width_q <= since_rise;
						end
						PH_SECOND: begin
							last_emit_q   <= data_s1.tick_now;
							first_rise_q  <= '0;
							first_width_q <= '0;
							phase_q       <= PH_IDLE;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	// a result only ever closes a second pulse and returns the pair to idle
	a_emit_idles: assert property (@(posedge clk) disable iff (!arst_n)
		advance && status.emit |=> phase_q == PH_IDLE && last_level_q == 1'b0)
		else $error("emit did not return pair capture to idle");

	// the second phase is only reached from a rising edge
	a_second_on_rise: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q != PH_SECOND && !(phase_eff == PH_FIRST && rise)
		|=> phase_q != PH_SECOND)
		else $error("second phase entered without a rising edge");

	// saturated magnitude never produces the most negative code
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit |-> speed != 32'h8000_0000)
		else $error("speed outside saturation range");

endmodule

>>> rtl/core/ppsc_result_reg.sv
// ppsc_result_reg: output register for result words, decouples the tracker from the receiver
// depends on ppsc_pkg and ppsc_result_if
`timescale 1ns / 1ps

module ppsc_result_reg import ppsc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  result_t       res,
	output logic          free,
	ppsc_result_if.source result
);

	logic    valid_q;
	result_t res_q;

	assign free                 = !valid_q || result.ready;
	assign result.valid         = valid_q;
	assign result.signed_speed  = res_q.signed_speed;
	assign result.swing_period  = res_q.swing_period;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	// a word is never loaded over one the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result word overwritten before it was taken");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q && res_q == $past(res))
		else $error("loaded result word not presented");

endmodule

>>> rtl/core/pulse_pair_speed_period_capture_core.sv
// pulse_pair_speed_period_capture_core: top level of the pulse pair speed and period capture
// depends on ppsc_pkg, ppsc_chan_if, ppsc_input_stage, ppsc_pair_tracker, ppsc_result_reg
`timescale 1ns / 1ps

// usage
// sample channel: one word per light gate sample (sensor_level, tick_now), valid/ready.
// result channel: one word (signed_speed, swing_period) at the falling edge of the second
// pulse of a pair; most samples produce no word.
// cfg_we / cfg_wdata write gap_timeout (reset value 700); write it only while the block idles.
// throughput: one sample per cycle, except while a sample that would emit waits on a
// stalled receiver. an accepted sample is held in the input register and evaluated against
// the pair state in the following cycle; if the output register is free, its word is loaded
// into it at the end of that cycle and result.valid is driven from the output register.
// in the pair state update, the timeout compare, edge decode and the width compare
// all act on the registered sample and the state registers.
// reset (arst_n low) clears the pair state, the emit timestamp and both channel valid flags.
// receiver stall: the output register holds the word; samples that produce no word keep
// flowing, a sample that would emit waits in the input register and sample.ready drops in
// that same cycle, so nothing is accepted behind it until the held word is taken.

module pulse_pair_speed_period_capture_core import ppsc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  tick_t         cfg_wdata,
	ppsc_sample_if.sink   sample,
	ppsc_result_if.source result
);

	logic        valid_s1;
	sample_t     data_s1;
	logic        advance;
	logic        out_free;
	trk_status_t status;

	assign advance = valid_s1 && (!status.emit || out_free);

	ppsc_input_stage u_input_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	ppsc_pair_tracker u_pair_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.advance   (advance),
		.status    (status)
	);

	ppsc_result_reg u_result_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && status.emit),
		.res    (status.res),
		.free   (out_free),
		.result (result)
	);

endmodule

>>> dv/pulse_pair_speed_period_capture_core_tb.sv
// pulse_pair_speed_period_capture_core_tb: self-checking bench for the pulse pair capture core
// depends on ppsc_pkg, ppsc_chan_if and the core; drives sample words, checks result words
`timescale 1ns / 1ps

module pulse_pair_speed_period_capture_core_tb;
	import ppsc_pkg::*;

	localparam int DRAIN_CYCLES = 8;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	tick_t cfg_wdata;

	ppsc_sample_if sample_ch ();
	ppsc_result_if result_ch ();

	pulse_pair_speed_period_capture_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	sample_t pending_samples[$];
	result_t expected_results[$];
	result_t due_result;
	int      samples_issued;
	int      samples_accepted;
	int      mismatches;
	int      send_idle_pct;
	int      recv_stall_pct;
	tick_t   cur_tick;

	// pair tracker state, mirrors the block
	tick_t   gap_limit;
	logic    trk_level;
	phase_t  trk_phase;
	tick_t   rise_tick;
	tick_t   pair_start_tick;
	tick_t   first_width;
	tick_t   emit_tick;

	task automatic track_sample(input logic level, input tick_t now);
		tick_t   width;
		tick_t   mag;
		result_t res;
		if (tick_t'(now - rise_tick) > gap_limit) begin
			trk_phase = PH_IDLE;
			trk_level = 1'b0;
		end
		if (level && !trk_level) begin
			rise_tick = now;
			if (trk_phase == PH_FIRST) begin
				trk_phase = PH_SECOND;
			end else begin
				pair_start_tick = now;
				trk_phase       = PH_FIRST;
			end
		end else if (!level && trk_level) begin
			width = now - rise_tick;
			if (trk_phase == PH_FIRST) begin
				first_width = width;
			end else if (trk_phase == PH_SECOND) begin
				mag = now - pair_start_tick;
				if (mag > SPEED_MAX)
					mag = SPEED_MAX;
				// strictly wider first pulse gives a negative speed
				res.signed_speed = (first_width > width) ? -mag : mag;
				res.swing_period = now - emit_tick;
				expected_results.push_back(res);
				emit_tick       = now;
				pair_start_tick = '0;
				first_width     = '0;
				trk_phase       = PH_IDLE;
			end
		end
		trk_level = level;
	endtask

	task automatic put_sample(input logic level, input tick_t step);
		sample_t s;
		cur_tick       = cur_tick + step;
		s.sensor_level = level;
		s.tick_now     = cur_tick;
		pending_samples.push_back(s);
		samples_issued++;
	endtask

	task automatic put_at(input logic level, input tick_t tick);
		cur_tick = tick;
		put_sample(level, '0);
	endtask

	// mostly inside the timeout, now and then right on it or just past it
	function automatic tick_t pick_step();
		tick_t lim;
		lim = gap_limit >> 2;
		if (lim == 0)
			lim = 1;
		case ($urandom_range(9))
			0: return '0;
			1: return gap_limit;
			2: return gap_limit + 1;
			default: return $urandom_range(lim, 1);
		endcase
	endfunction

	task automatic gen_pair();
		tick_t w1;
		tick_t w2;
		w1 = pick_step();
		w2 = ($urandom_range(3) == 0) ? w1 : pick_step();
		put_sample(1'b0, pick_step());
		put_sample(1'b1, pick_step());
		if ($urandom_range(4) == 0)
			put_sample(1'b1, '0);
		put_sample(1'b0, w1);
		if ($urandom_range(4) == 0)
			put_sample(1'b0, pick_step());
		put_sample(1'b1, pick_step());
		put_sample(1'b0, w2);
	endtask

	task automatic gen_random(input int n);
		int stop_at;
		int roll;
		stop_at = samples_issued + n;
		while (samples_issued < stop_at) begin
			roll = $urandom_range(99);
			if (roll < 75) begin
				gen_pair();
			end else if (roll < 88) begin
				cur_tick = $urandom();
				put_sample($urandom_range(1), '0);
			end else begin
				// half a pair, then silence long enough to restart capture
				put_sample(1'b1, pick_step());
				put_sample(1'b0, pick_step());
				put_sample(1'b0, gap_limit + 1);
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (samples_accepted != samples_issued || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic start_phase(input tick_t gap, input int send_pct, input int recv_pct);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= gap;
		@(posedge clk);
		cfg_we         <= 1'b0;
		gap_limit      = gap;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sample driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				track_sample(sample_ch.sensor_level, sample_ch.tick_now);
				samples_accepted++;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					sample_ch.valid        <= 1'b1;
					sample_ch.sensor_level <= pending_samples[0].sensor_level;
					sample_ch.tick_now     <= pending_samples[0].tick_now;
					void'(pending_samples.pop_front());
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, actual speed %0d period %0d",
						$time, result_ch.signed_speed, result_ch.swing_period);
				end else begin
					due_result = expected_results.pop_front();
					if (due_result.signed_speed !== result_ch.signed_speed) begin
						mismatches++;
						$display("%0t: signed_speed expected %0d actual %0d",
							$time, due_result.signed_speed, result_ch.signed_speed);
					end
					if (due_result.swing_period !== result_ch.swing_period) begin
						mismatches++;
						$display("%0t: swing_period expected %0d actual %0d",
							$time, due_result.swing_period, result_ch.swing_period);
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("pulse_pair_speed_period_capture_core_tb: FAIL");
		$finish;
	end

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.sensor_level = 1'b0;
		sample_ch.tick_now     = '0;
		result_ch.ready        = 1'b0;
		samples_issued         = 0;
		samples_accepted       = 0;
		mismatches             = 0;
		send_idle_pct          = 0;
		recv_stall_pct         = 0;
		cur_tick               = '0;
		gap_limit              = GAP_TIMEOUT_RST;
		trk_level              = 1'b0;
		trk_phase              = PH_IDLE;
		rise_tick              = '0;
		pair_start_tick        = '0;
		first_width            = '0;
		emit_tick              = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset timeout of 700
		put_at(1'b0, 32'd0);
		put_at(1'b1, 32'd5);
		put_at(1'b1, 32'd6);           // held high, no edge
		put_at(1'b0, 32'd15);
		put_at(1'b1, 32'd20);
		put_at(1'b0, 32'd30);          // equal widths, positive speed
		put_at(1'b0, 32'd31);          // idle, nothing recorded
		put_at(1'b1, 32'd731);         // just past the timeout
		put_at(1'b0, 32'd751);
		put_at(1'b1, 32'd1431);        // exactly at the timeout, pair survives
		put_at(1'b0, 32'd1432);        // first pulse wider, negative speed
		put_at(1'b1, 32'd2000);
		put_at(1'b0, 32'd2001);
		put_at(1'b1, 32'd2702);        // timeout restarts the pair on this rise
		put_at(1'b0, 32'd2710);
		put_at(1'b1, 32'd2720);
		put_at(1'b0, 32'd2740);        // second pulse wider
		put_at(1'b1, 32'hFFFF_FF00);
		put_at(1'b0, 32'hFFFF_FF10);
		put_at(1'b1, 32'hFFFF_FFFF);
		put_at(1'b0, 32'h0000_0020);   // ticks wrap past zero
		put_at(1'b1, 32'h0000_0100);
		put_at(1'b1, 32'h0000_0420);   // timeout forces stored level low, so a new rise
		put_at(1'b0, 32'h0000_0484);
		put_at(1'b0, 32'h0000_0D00);

		// widest timeout, speed saturation both ways
		start_phase(32'hFFFF_FFFF, 0, 0);
		put_sample(1'b0, 32'd1);
		put_sample(1'b1, 32'd1);
		put_sample(1'b0, 32'h3000_0000);
		put_sample(1'b1, 32'h3000_0000);
		put_sample(1'b0, 32'h3000_0000);
		put_sample(1'b1, 32'd5);
		put_sample(1'b0, 32'h5000_0000);
		put_sample(1'b1, 32'h1000_0000);
		put_sample(1'b0, 32'h2000_0000);
		gen_random(80);

		start_phase(32'd0, 69, 0);
		gen_random(80);

		start_phase($urandom_range(2000, 50), 0, 69);
		gen_random(85);

		start_phase(GAP_TIMEOUT_RST, 15, 15);
		gen_random(85);

		start_phase($urandom_range(300, 1), 0, 69);
		gen_random(85);

		start_phase($urandom(), 69, 0);
		gen_random(85);

		wait_drained();
		if (mismatches == 0) begin
			$display("pulse_pair_speed_period_capture_core_tb: PASS");
		end else begin
			$display("pulse_pair_speed_period_capture_core_tb: FAIL");
		end
		$finish;
	end

endmodule
